// ===== rtl/core/dsfa_pkg.sv =====
// Package for the dust sensor frame averager: item types, frame constants
// and datapath widths. No dependencies; the interfaces, top level and testbench use it.
package dsfa_pkg;

    localparam int FRAME_LEN  = 10;
    localparam int MAX_FRAMES = 255;
    localparam int TOTAL_W    = 24;
    localparam int STEP_W     = $clog2(TOTAL_W);
    localparam int COUNT_W    = 4;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] CMD_BYTE  = 8'hC0;
    localparam logic [7:0] TAIL_BYTE = 8'hAB;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_DATA = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [15:0] pm25_average;
        logic [15:0] pm10_average;
        logic [7:0]  frames_used;
    } t_out_item;

endpackage

// ===== rtl/core/dsfa_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
// Depends on dsfa_pkg for the payload types.
interface dsfa_in_if;
    logic                valid;
    logic                ready;
    dsfa_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsfa_out_if;
    logic                valid;
    logic                ready;
    dsfa_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dust_sensor_frame_averager.sv =====
// Top level of the dust sensor frame averager. Uses dsfa_pkg and the stream
// interfaces in dsfa_if.sv.
//
// The block watches the byte stream of a particulate sensor UART. Every 0xAA
// byte closes the bytes collected since the previous 0xAA and opens a new
// frame with itself as byte 0; the bytes before the very first 0xAA are
// thrown away. A closed frame is counted when it is exactly ten bytes long,
// carries 0xC0 in byte 1 and 0xAB in byte 9, and byte 8 equals the 8-bit
// sum of bytes 2 to 7. Its little-endian PM2.5 (bytes 2 and 3) and PM10
// (bytes 4 and 5) readings, in tenths of a microgram per cubic metre, are
// added into 24-bit running totals that saturate, and the frame count is
// bumped until it reaches its limit, after which further frames are ignored.
// Bytes past the tenth of a frame are dropped and spoil that frame. A read
// request returns one result: status 0 with the truncated means and the frame
// count, or status 1 with zeros when no valid frame was seen, and it then
// clears all state, including a partly received frame. A read request
// produces no result until its result transfer; byte transfers produce none.
// Sequencing: a byte that does not complete a valid frame leaves the block
// idle. A byte that completes one starts S_ADD, where both totals are updated
// by a bit-serial adder, one bit per cycle over the 24 total bits. A read
// enters S_DIV for 24 steps of a bit-serial restoring divider (both means
// are divided side by side), and S_DONE then loads the result register;
// a read with no valid frame skips the divider. If the previous
// result has not been taken yet, the read waits for it before loading.
// Input is not taken while the adder or divider is running. The result sits
// in an output register, so byte transfers continue while a result waits.
module dust_sensor_frame_averager (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dsfa_in_if.sink        i_in,
    dsfa_out_if.source     o_res
);
    import dsfa_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         r_state;
    logic [STEP_W-1:0]  r_step;
    logic [7:0]         r_store [FRAME_LEN];
    logic [COUNT_W-1:0] r_byte_count;
    logic               r_header_seen;
    logic [7:0]         r_frames;
    logic [TOTAL_W-1:0] r_pm25_total;
    logic [TOTAL_W-1:0] r_pm10_total;
    logic [15:0]        r_pm25_addend;
    logic [15:0]        r_pm10_addend;
    logic               r_pm25_carry;
    logic               r_pm10_carry;
    logic [7:0]         r_pm25_rem;
    logic [7:0]         r_pm10_rem;
    logic               r_no_data;
    logic               r_out_valid;
    t_out_item          r_out;

    t_in_item           in_item;
    logic               in_fire;
    logic               byte_fire;
    logic               read_fire;
    logic               is_sync;
    logic [COUNT_W-1:0] base_count;
    logic [7:0]         check_sum;
    logic               frame_ok;
    logic               last_step;
    logic               out_free;

    // Serial adder and divider bit cells.
    logic               pm25_sum_bit;
    logic               pm10_sum_bit;
    logic               n_pm25_carry;
    logic               n_pm10_carry;
    logic [8:0]         pm25_rem_sh;
    logic [8:0]         pm10_rem_sh;
    logic               pm25_q_bit;
    logic               pm10_q_bit;
    logic [8:0]         n_pm25_rem;
    logic [8:0]         n_pm10_rem;

    assign in_item   = i_in.data;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire   = i_in.valid && i_in.ready;
    assign byte_fire = in_fire && (in_item.kind == KIND_BYTE);
    assign read_fire = in_fire && (in_item.kind == KIND_READ);

    assign is_sync    = (in_item.rx_byte == SYNC_BYTE);
    assign base_count = is_sync ? '0 : r_byte_count;

    // Checks on the frame being closed, taken before byte 0 is overwritten.
    assign check_sum = r_store[2] + r_store[3] + r_store[4]
                     + r_store[5] + r_store[6] + r_store[7];
    assign frame_ok  = r_header_seen
                    && (r_byte_count == COUNT_W'(FRAME_LEN))
                    && (r_store[1] == CMD_BYTE)
                    && (r_store[9] == TAIL_BYTE)
                    && (check_sum == r_store[8])
                    && (int'(r_frames) < MAX_FRAMES);

    assign last_step = (r_step == STEP_W'(TOTAL_W - 1));
    assign out_free  = !r_out_valid || o_res.ready;

    // One full-adder cell per total, fed LSB first.
    assign pm25_sum_bit = r_pm25_total[0] ^ r_pm25_addend[0] ^ r_pm25_carry;
    assign pm10_sum_bit = r_pm10_total[0] ^ r_pm10_addend[0] ^ r_pm10_carry;
    assign n_pm25_carry = (r_pm25_total[0] & r_pm25_addend[0])
                        | (r_pm25_carry & (r_pm25_total[0] ^ r_pm25_addend[0]));
    assign n_pm10_carry = (r_pm10_total[0] & r_pm10_addend[0])
                        | (r_pm10_carry & (r_pm10_total[0] ^ r_pm10_addend[0]));

    // One restoring-division step per total, fed MSB first. The quotient
    // bits shift into the total register as the dividend bits leave it.
    assign pm25_rem_sh = {r_pm25_rem, r_pm25_total[TOTAL_W-1]};
    assign pm10_rem_sh = {r_pm10_rem, r_pm10_total[TOTAL_W-1]};
    assign pm25_q_bit  = (pm25_rem_sh >= {1'b0, r_frames});
    assign pm10_q_bit  = (pm10_rem_sh >= {1'b0, r_frames});
    assign n_pm25_rem  = pm25_q_bit ? (pm25_rem_sh - {1'b0, r_frames}) : pm25_rem_sh;
    assign n_pm10_rem  = pm10_q_bit ? (pm10_rem_sh - {1'b0, r_frames}) : pm10_rem_sh;

    // Frame buffer: written only, its contents need no reset.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (byte_fire && (base_count == COUNT_W'(i))) begin
                r_store[i] <= in_item.rx_byte;
            end
        end
    end

    // Working registers of the adder and divider.
    always_ff @(posedge i_clk) begin
        if (byte_fire && is_sync && frame_ok) begin
            r_pm25_addend <= {r_store[3], r_store[2]};
            r_pm10_addend <= {r_store[5], r_store[4]};
            r_pm25_carry  <= 1'b0;
            r_pm10_carry  <= 1'b0;
        end else if (r_state == S_ADD) begin
            r_pm25_addend <= {1'b0, r_pm25_addend[15:1]};
            r_pm10_addend <= {1'b0, r_pm10_addend[15:1]};
            r_pm25_carry  <= n_pm25_carry;
            r_pm10_carry  <= n_pm10_carry;
        end
        if (read_fire) begin
            r_pm25_rem <= '0;
            r_pm10_rem <= '0;
        end else if (r_state == S_DIV) begin
            r_pm25_rem <= n_pm25_rem[7:0];
            r_pm10_rem <= n_pm10_rem[7:0];
        end
    end

    // Control, frame tracking, totals and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= '0;
            r_byte_count  <= '0;
            r_header_seen <= 1'b0;
            r_frames      <= '0;
            r_pm25_total  <= '0;
            r_pm10_total  <= '0;
            r_no_data     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // A new result may be loaded in the cycle the old one is taken.
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (byte_fire) begin
                        if (is_sync) begin
                            r_header_seen <= 1'b1;
                        end
                        if (base_count < COUNT_W'(FRAME_LEN)) begin
                            r_byte_count <= base_count + 1'b1;
                        end else begin
                            r_byte_count <= COUNT_W'(FRAME_LEN + 1);
                        end
                        if (is_sync && frame_ok) begin
                            r_frames <= r_frames + 1'b1;
                            r_state  <= S_ADD;
                        end
                    end else if (read_fire) begin
                        r_no_data <= (r_frames == '0);
                        r_state   <= (r_frames == '0) ? S_DONE : S_DIV;
                    end
                end
                S_ADD: begin
                    r_step <= r_step + 1'b1;
                    if (last_step) begin
                        // A carry out of the top bit saturates the total.
                        r_pm25_total <= n_pm25_carry ? '1
                                      : {pm25_sum_bit, r_pm25_total[TOTAL_W-1:1]};
                        r_pm10_total <= n_pm10_carry ? '1
                                      : {pm10_sum_bit, r_pm10_total[TOTAL_W-1:1]};
                        r_state      <= S_IDLE;
                    end else begin
                        r_pm25_total <= {pm25_sum_bit, r_pm25_total[TOTAL_W-1:1]};
                        r_pm10_total <= {pm10_sum_bit, r_pm10_total[TOTAL_W-1:1]};
                    end
                end
                S_DIV: begin
                    r_step       <= r_step + 1'b1;
                    r_pm25_total <= {r_pm25_total[TOTAL_W-2:0], pm25_q_bit};
                    r_pm10_total <= {r_pm10_total[TOTAL_W-2:0], pm10_q_bit};
                    if (last_step) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_byte_count  <= '0;
                        r_header_seen <= 1'b0;
                        r_frames      <= '0;
                        r_pm25_total  <= '0;
                        r_pm10_total  <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload; loaded together with the valid flag.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            if (r_no_data) begin
                r_out.status       <= STATUS_NO_DATA;
                r_out.pm25_average <= '0;
                r_out.pm10_average <= '0;
                r_out.frames_used  <= '0;
            end else begin
                r_out.status       <= STATUS_OK;
                r_out.pm25_average <= r_pm25_total[15:0];
                r_out.pm10_average <= r_pm10_total[15:0];
                r_out.frames_used  <= r_frames;
            end
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// ===== rtl/core/dsfa_checker.sv =====
// Port-level checks for the dust sensor frame averager, and the bind that
// attaches them to the top level. Depends only on the top level's ports.
module dsfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_kind,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_status,
    input logic [15:0] i_res_pm25,
    input logic [15:0] i_res_pm10,
    input logic [7:0]  i_res_frames
);

    // A result that is not taken stays offered.
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before its transfer");

    // A read request occupies the block for at least the next cycle.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind |=> !i_in_ready)
        else $error("input taken right after a read request");

    // A result without data carries only zeros.
    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status |->
            (i_res_pm25 == '0) && (i_res_pm10 == '0) && (i_res_frames == '0))
        else $error("no-data result with nonzero fields");

    // A result with valid averages is backed by at least one frame.
    a_ok_has_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_status |-> (i_res_frames != '0))
        else $error("valid averages reported with no frame");

endmodule

bind dust_sensor_frame_averager dsfa_checker u_dsfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_kind    (i_in.data.kind),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.data.status),
    .i_res_pm25   (o_res.data.pm25_average),
    .i_res_pm10   (o_res.data.pm10_average),
    .i_res_frames (o_res.data.frames_used)
);

// ===== test/dust_sensor_frame_averager_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dust_sensor_frame_averager: streams sensor bytes and read
// requests, predicts most average results and checks each result transfer field by field.
// Depends on dsfa_pkg, the stream interfaces in dsfa_if.sv and the block's RTL.
module dust_sensor_frame_averager_tb;
    import dsfa_pkg::*;

    // A bound on the run, many times over what a correct run needs.
    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int RANDOM_ITEMS    = 1200;
    // The random part is split into three stretches of idling behavior; the last runs to the end.
    localparam int PHASE_ITEMS     = 400;
    localparam int HOLD_OFF_CYCLES = 500;
    // Long enough to cover a whole read with room to spare.
    localparam int DRAIN_CYCLES    = 60;

    typedef logic [7:0] t_byte_seq [$];

    // Ways in which a generated sensor frame can be spoiled.
    typedef enum int {
        FLAW_NONE,
        FLAW_CORRUPT,
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_RESYNC
    } t_flaw;

    // One input transfer, with a typed-in expected result for the few reads
    // whose answer is obvious; all other reads are predicted.
    typedef struct {
        t_in_item  item;
        bit        has_want;
        t_out_item want;
    } t_traffic_entry;

    logic i_clk;
    logic i_rst_n;

    dsfa_in_if  in_bus ();
    dsfa_out_if res_bus ();

    dust_sensor_frame_averager i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_res   (res_bus)
    );

    // Predicted state of the averager.
    logic [7:0]  rx_frame [FRAME_LEN];
    logic [3:0]  rx_fill;
    logic        sync_found;
    logic [7:0]  frames_counted;
    logic [23:0] pm25_sum;
    logic [23:0] pm10_sum;

    t_traffic_entry sensor_traffic [$];
    t_out_item      awaited_averages [$];

    int     src_idle_pct;
    int     sink_idle_pct;
    bit     hold_off_ask;
    int     mismatches;
    longint cycles;

    // Free-running clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every run is bounded; a hang is a failure.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("dust_sensor_frame_averager_tb: errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [23:0] add_clamped(input logic [23:0] total,
                                                input logic [15:0] reading);
        logic [24:0] wide;
        wide = {1'b0, total} + reading;
        return wide[24] ? 24'hFF_FFFF : wide[23:0];
    endfunction

    task automatic clear_frame_tally();
        rx_fill        = '0;
        sync_found     = 1'b0;
        frames_counted = '0;
        pm25_sum       = '0;
        pm10_sum       = '0;
    endtask

    // Advances the predicted state by one accepted transfer. A read yields
    // the averages over all valid frames closed so far and then clears
    // everything, including a frame that is still being collected.
    task automatic update_frame_tally(input t_in_item it, output bit produced,
                                      output t_out_item avg);
        logic [7:0] chk;
        produced = 1'b0;
        avg      = '0;
        if (it.kind == KIND_READ) begin
            produced = 1'b1;
            if (sync_found && frames_counted != 0) begin
                avg.status       = STATUS_OK;
                avg.pm25_average = 16'(pm25_sum / frames_counted);
                avg.pm10_average = 16'(pm10_sum / frames_counted);
                avg.frames_used  = frames_counted;
            end else begin
                avg.status = STATUS_NO_DATA;
            end
            clear_frame_tally();
        end else begin
            if (it.rx_byte == SYNC_BYTE) begin
                // The first sync byte only throws away what came before it;
                // every later one closes the frame in progress.
                if (!sync_found) begin
                    sync_found = 1'b1;
                end else if (rx_fill == FRAME_LEN && rx_frame[1] == CMD_BYTE
                             && rx_frame[9] == TAIL_BYTE) begin
                    chk = '0;
                    for (int k = 2; k <= 7; k++) chk += rx_frame[k];
                    // A full frame count ignores further frames altogether.
                    if (chk == rx_frame[8] && frames_counted < MAX_FRAMES) begin
                        frames_counted++;
                        pm25_sum = add_clamped(pm25_sum, {rx_frame[3], rx_frame[2]});
                        pm10_sum = add_clamped(pm10_sum, {rx_frame[5], rx_frame[4]});
                    end
                end
                rx_fill = '0;
            end
            // Bytes past the tenth are dropped and mark the frame as overrun.
            if (rx_fill < FRAME_LEN) begin
                rx_frame[rx_fill] = it.rx_byte;
                rx_fill++;
            end else begin
                rx_fill = 4'(FRAME_LEN + 1);
            end
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        t_traffic_entry e;
        e.item.kind    = KIND_BYTE;
        e.item.rx_byte = b;
        e.has_want     = 1'b0;
        e.want         = '0;
        sensor_traffic.push_back(e);
    endtask

    task automatic add_bytes(input t_byte_seq seq);
        foreach (seq[k]) add_byte(seq[k]);
    endtask

    // The byte field is unused on a read, so it carries random bits.
    task automatic add_read(input bit has_want, input t_out_item want);
        t_traffic_entry e;
        e.item.kind    = KIND_READ;
        e.item.rx_byte = 8'($urandom_range(255));
        e.has_want     = has_want;
        e.want         = want;
        sensor_traffic.push_back(e);
    endtask

    // A reading byte that never looks like a sync byte, leaning toward the
    // extremes so that both means reach zero and full scale.
    function automatic logic [7:0] sensor_payload();
        logic [7:0] b;
        case ($urandom_range(7))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: begin
                do begin
                    b = 8'($urandom_range(255));
                end while (b == SYNC_BYTE);
            end
        endcase
        return b;
    endfunction

    // Queues one frame that starts with its own sync byte; the frame is closed
    // by whatever sync byte follows it.
    task automatic add_frame(input t_flaw flaw);
        logic [7:0] f [FRAME_LEN];
        logic [7:0] chk;
        int cut;
        int pos;
        f[0] = SYNC_BYTE;
        f[1] = CMD_BYTE;
        for (int k = 2; k <= 6; k++) f[k] = sensor_payload();
        // A checksum equal to the sync byte would split the frame, so the
        // last reading byte is redrawn until it is not.
        do begin
            f[7] = sensor_payload();
            chk  = '0;
            for (int k = 2; k <= 7; k++) chk += f[k];
        end while (chk == SYNC_BYTE);
        f[8] = chk;
        f[9] = TAIL_BYTE;
        cut  = FRAME_LEN;
        case (flaw)
            FLAW_CORRUPT: begin
                pos = $urandom_range(1, FRAME_LEN - 1);
                do begin
                    chk = sensor_payload();
                end while (chk == f[pos]);
                f[pos] = chk;
            end
            FLAW_SHORT:  cut = $urandom_range(1, FRAME_LEN - 1);
            FLAW_RESYNC: f[$urandom_range(2, FRAME_LEN - 1)] = SYNC_BYTE;
            default: ;
        endcase
        for (int k = 0; k < cut; k++) add_byte(f[k]);
        if (flaw == FLAW_LONG) begin
            repeat ($urandom_range(1, 4)) add_byte(sensor_payload());
        end
    endtask

    // Result side: ready follows the idle rate of the current stretch, except
    // during one long hold-off that lets the block fill up and stall its input.
    initial begin
        int stall_left;
        stall_left    = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else if (hold_off_ask) begin
                hold_off_ask  = 1'b0;
                stall_left    = HOLD_OFF_CYCLES - 1;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Every result transfer is matched against the oldest expected result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (awaited_averages.size() == 0) begin
                flag_mismatch($sformatf("result %h with no read pending", res_bus.data));
            end else begin
                want = awaited_averages.pop_front();
                if (res_bus.data.status !== want.status)
                    flag_mismatch($sformatf("status %b, wanted %b",
                                            res_bus.data.status, want.status));
                if (res_bus.data.pm25_average !== want.pm25_average)
                    flag_mismatch($sformatf("pm25_average %h, wanted %h",
                                            res_bus.data.pm25_average, want.pm25_average));
                if (res_bus.data.pm10_average !== want.pm10_average)
                    flag_mismatch($sformatf("pm10_average %h, wanted %h",
                                            res_bus.data.pm10_average, want.pm10_average));
                if (res_bus.data.frames_used !== want.frames_used)
                    flag_mismatch($sformatf("frames_used %0d, wanted %0d",
                                            res_bus.data.frames_used, want.frames_used));
            end
        end
    end

    // Stimulus: builds the whole byte stream first, then drives it transfer
    // by transfer and predicts the result of each read as it is accepted.
    initial begin
        int        random_start;
        int        n_frames;
        bit        produced;
        t_out_item avg;

        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        i_rst_n       = 1'b0;
        src_idle_pct  = 36;
        sink_idle_pct = 51;
        hold_off_ask  = 1'b0;
        mismatches    = 0;
        clear_frame_tally();

        // Directed part. A read straight after reset has nothing to report.
        add_read(1'b1, t_out_item'{STATUS_NO_DATA, 16'd0, 16'd0, 8'd0});
        // A stray byte before the first sync byte is thrown away unchecked.
        add_bytes('{8'h00});
        // A valid frame with both readings at full scale.
        add_bytes('{SYNC_BYTE, CMD_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'hFC, TAIL_BYTE});
        // An all-zero frame that would be valid but runs one byte too long.
        add_bytes('{SYNC_BYTE, CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, TAIL_BYTE, 8'h00});
        // This sync byte rejects the overrun frame and opens one that the
        // read below must ignore and clear.
        add_bytes('{SYNC_BYTE});
        add_read(1'b1, t_out_item'{STATUS_OK, 16'hFFFF, 16'hFFFF, 8'd1});

        // One more frame than the count can hold, so the last one is ignored.
        repeat (MAX_FRAMES + 1) add_frame(FLAW_NONE);
        add_byte(SYNC_BYTE);
        add_read(1'b0, '0);

        // Random part: mostly well-formed frames with random readings, some
        // spoiled ones, stray bytes and plain noise, each window ended by a read.
        random_start = sensor_traffic.size();
        while (sensor_traffic.size() - random_start < RANDOM_ITEMS) begin
            repeat ($urandom_range(0, 2)) add_byte(sensor_payload());
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(5, 20)) add_byte(8'($urandom_range(255)));
            end
            n_frames = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
            repeat (n_frames) begin
                if ($urandom_range(9) < 7) add_frame(FLAW_NONE);
                else add_frame(t_flaw'($urandom_range(FLAW_CORRUPT, FLAW_RESYNC)));
            end
            // Usually the last frame is closed; otherwise the read drops it.
            if ($urandom_range(3) != 0) add_byte(SYNC_BYTE);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 5)) add_byte(sensor_payload());
            end
            add_read(1'b0, '0);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (sensor_traffic[i]) begin
            // Idling: receiver-heavy first, then sender-heavy, then none, with
            // the long result hold-off at the start of the last stretch.
            if (i >= random_start + 2 * PHASE_ITEMS) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                if (i == random_start + 2 * PHASE_ITEMS) hold_off_ask = 1'b1;
            end else if (i >= random_start + PHASE_ITEMS) begin
                src_idle_pct  = 51;
                sink_idle_pct = 36;
            end
            @(negedge i_clk);
            while ($urandom_range(99) < src_idle_pct) begin
                in_bus.valid <= 1'b0;
                @(negedge i_clk);
            end
            in_bus.valid <= 1'b1;
            in_bus.data  <= sensor_traffic[i].item;
            do begin
                @(posedge i_clk);
            end while (in_bus.ready !== 1'b1);
            update_frame_tally(sensor_traffic[i].item, produced, avg);
            if (produced) begin
                awaited_averages.push_back(sensor_traffic[i].has_want
                                           ? sensor_traffic[i].want : avg);
            end
        end
        @(negedge i_clk);
        in_bus.valid <= 1'b0;

        // Drain: wait for every pending result, then a little longer so
        // that a stray extra result would still be caught.
        while (awaited_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("dust_sensor_frame_averager_tb: clean");
        end else begin
            $display("dust_sensor_frame_averager_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dsfa_pkg.sv
rtl/core/dsfa_if.sv
rtl/core/dust_sensor_frame_averager.sv
rtl/core/dsfa_checker.sv
test/dust_sensor_frame_averager_tb.sv
